// File: rtl/leg_forward_kinematics_unit_assert.svh
// Assertion macros used by the leg kinematics checker.
`ifndef LEG_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define LEG_FORWARD_KINEMATICS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lfk_pkg.sv
// ----------------------------------------------------------------------------
// lfk_pkg
// Types, widths and constants of the leg forward kinematics unit.
// ----------------------------------------------------------------------------
package lfk_pkg;

   localparam int AW  = 35;  // wide angle before wrap
   localparam int CW  = 34;  // CORDIC x and y
   localparam int ZW  = 34;  // CORDIC residual angle
   localparam int PW  = 52;  // length times sine products
   localparam int XW  = 20;  // rounded x offset
   localparam int QW  = 68;  // hip rotation products
   localparam int DW  = 24;  // rounded y and z offsets
   localparam int SW  = 25;  // sum before saturation
   localparam int OW  = 18;  // output coordinate

   localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [SW-1:0] SAT_HI = 25'sd131071;
   localparam logic signed [SW-1:0] SAT_LO = -25'sd131072;

   typedef enum logic [2:0] {
      REG_MOUNT_X,
      REG_MOUNT_Y,
      REG_MOUNT_Z,
      REG_RIGHT_SIDE,
      REG_UPPER_LENGTH,
      REG_LOWER_LENGTH,
      REG_LATERAL_OFFSET
   } csr_index_type;

   typedef struct packed {
      logic signed [OW-1:0] mount_x;
      logic signed [OW-1:0] mount_y;
      logic signed [OW-1:0] mount_z;
      logic                 right_side;
      logic [15:0]          upper_length;
      logic [15:0]          lower_length;
      logic [15:0]          lateral_offset;
   } cfg_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } lane_type;

   typedef struct packed {
      lane_type hip;
      lane_type thigh;
      lane_type sum;
   } trio_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      case (idx)
         0:  return 34'sd843314856;
         1:  return 34'sd497837829;
         2:  return 34'sd263043836;
         3:  return 34'sd133525158;
         4:  return 34'sd67021686;
         5:  return 34'sd33543515;
         6:  return 34'sd16775850;
         7:  return 34'sd8388437;
         8:  return 34'sd4194282;
         9:  return 34'sd2097149;
         10: return 34'sd1048575;
         11: return 34'sd524287;
         12: return 34'sd262143;
         13: return 34'sd131071;
         14: return 34'sd65535;
         15: return 34'sd32767;
         16: return 34'sd16383;
         17: return 34'sd8191;
         18: return 34'sd4095;
         19: return 34'sd2047;
         20: return 34'sd1023;
         21: return 34'sd511;
         22: return 34'sd255;
         23: return 34'sd127;
         default: return '0;
      endcase
   endfunction

   // Wrap into [-pi, pi], then fold into [-pi/2, pi/2] and mark the sign flip.
   function automatic lane_type prep_lane(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] w;
      logic signed [AW-1:0] f;
      lane_type             r;
      if (a > PI_Q30) begin
         w = a - TWO_PI_Q30;
      end else if (a < -PI_Q30) begin
         w = a + TWO_PI_Q30;
      end else begin
         w = a;
      end
      r.flip = 1'b1;
      if (w > HALF_PI_Q30) begin
         f = w - PI_Q30;
      end else if (w < -HALF_PI_Q30) begin
         f = w + PI_Q30;
      end else begin
         f = w;
         r.flip = 1'b0;
      end
      r.x = GAIN_Q30;
      r.y = '0;
      r.z = ZW'(f);
      return r;
   endfunction

   function automatic logic signed [OW-1:0] sat_out(input logic signed [SW-1:0] v);
      if (v > SAT_HI) begin
         return OW'(SAT_HI);
      end else if (v < SAT_LO) begin
         return OW'(SAT_LO);
      end else begin
         return OW'(v);
      end
   endfunction

endpackage

// File: rtl/lfk_cordic_cell.sv
// ----------------------------------------------------------------------------
// lfk_cordic_cell
// One CORDIC rotation step on the hip, thigh and thigh+calf lanes.
// ----------------------------------------------------------------------------
module lfk_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  lfk_pkg::trio_type up_data,
   input  logic              down_take,
   output logic              valid,
   output lfk_pkg::trio_type data,
   output logic              take
);
   import lfk_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = atan_entry(STEP);

   logic     valid_ff;
   trio_type data_ff;
   trio_type data_in;

   function automatic lane_type rotate(input lane_type a);
      lane_type             r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = $signed(a.y) >>> STEP;
      dy = $signed(a.x) >>> STEP;
      r  = a;
      if ($signed(a.z) >= 0) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - ATAN;
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + ATAN;
      end
      return r;
   endfunction

   always_comb begin
      data_in.hip   = rotate(up_data.hip);
      data_in.thigh = rotate(up_data.thigh);
      data_in.sum   = rotate(up_data.sum);
   end

   assign take  = !valid_ff || down_take;
   assign valid = valid_ff;
   assign data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/lfk_tail.sv
// ----------------------------------------------------------------------------
// lfk_tail
// Link products, hip rotation, mount offset and saturation, five stages.
// ----------------------------------------------------------------------------
module lfk_tail (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   input  lfk_pkg::trio_type             up_data,
   input  lfk_pkg::cfg_type              cfg,
   output logic                          take,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_x,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_y,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_z
);
   import lfk_pkg::*;

   localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;
   localparam logic signed [PW-1:0] RND16 = PW'(1) <<< 15;
   localparam logic signed [QW-1:0] RND44 = QW'(1) <<< 43;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic t1, t2, t3, t4, t5;

   // stage 1
   logic signed [PW-1:0] us1_ff, ls12_ff, uc1_ff, lc12_ff;
   logic signed [CW-1:0] ch1_ff, sh1_ff;
   logic signed [CW-1:0] c_h, s_h, c_1, s_1, c_12, s_12;
   logic signed [16:0]   len_u, len_l;
   // stage 2
   logic signed [PW-1:0] sum_x, sum_z;
   logic signed [XW-1:0] x2_ff;
   logic signed [ZW-1:0] z2_ff;
   logic signed [CW-1:0] ch2_ff, sh2_ff;
   // stage 3
   logic signed [CW-1:0] y_in;
   logic signed [QW-1:0] cy_ff, sz_ff, sy_ff, cz_ff;
   logic signed [XW-1:0] x3_ff;
   // stage 4
   logic signed [DW-1:0] dy_ff, dz_ff;
   logic signed [XW-1:0] x4_ff;
   // stage 5
   logic signed [OW-1:0] fx_ff, fy_ff, fz_ff;

   assign t5   = !v5_ff || !rsp_stall;
   assign t4   = !v4_ff || t5;
   assign t3   = !v3_ff || t4;
   assign t2   = !v2_ff || t3;
   assign t1   = !v1_ff || t2;
   assign take = t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (t1) v1_ff <= up_valid;
         if (t2) v2_ff <= v1_ff;
         if (t3) v3_ff <= v2_ff;
         if (t4) v4_ff <= v3_ff;
         if (t5) v5_ff <= v4_ff;
      end
   end

   // Undo the half-turn fold.
   always_comb begin
      c_h   = up_data.hip.flip   ? -up_data.hip.x   : up_data.hip.x;
      s_h   = up_data.hip.flip   ? -up_data.hip.y   : up_data.hip.y;
      c_1   = up_data.thigh.flip ? -up_data.thigh.x : up_data.thigh.x;
      s_1   = up_data.thigh.flip ? -up_data.thigh.y : up_data.thigh.y;
      c_12  = up_data.sum.flip   ? -up_data.sum.x   : up_data.sum.x;
      s_12  = up_data.sum.flip   ? -up_data.sum.y   : up_data.sum.y;
      len_u = $signed({1'b0, cfg.upper_length});
      len_l = $signed({1'b0, cfg.lower_length});
      sum_x = -(us1_ff + ls12_ff) + RND30;
      sum_z = -(uc1_ff + lc12_ff) + RND16;
      y_in  = cfg.right_side ? -CW'($signed({1'b0, cfg.lateral_offset, 14'b0}))
                             :  CW'($signed({1'b0, cfg.lateral_offset, 14'b0}));
   end

   always_ff @(posedge clock) begin
      if (t1) begin
         us1_ff  <= PW'(len_u) * PW'(s_1);
         ls12_ff <= PW'(len_l) * PW'(s_12);
         uc1_ff  <= PW'(len_u) * PW'(c_1);
         lc12_ff <= PW'(len_l) * PW'(c_12);
         ch1_ff  <= c_h;
         sh1_ff  <= s_h;
      end
      if (t2) begin
         x2_ff  <= XW'(sum_x >>> 30);
         z2_ff  <= ZW'(sum_z >>> 16);
         ch2_ff <= ch1_ff;
         sh2_ff <= sh1_ff;
      end
      if (t3) begin
         cy_ff <= QW'(ch2_ff) * QW'(y_in);
         sz_ff <= QW'(sh2_ff) * QW'(z2_ff);
         sy_ff <= QW'(sh2_ff) * QW'(y_in);
         cz_ff <= QW'(ch2_ff) * QW'(z2_ff);
         x3_ff <= x2_ff;
      end
      if (t4) begin
         dy_ff <= DW'((cy_ff - sz_ff + RND44) >>> 44);
         dz_ff <= DW'((sy_ff + cz_ff + RND44) >>> 44);
         x4_ff <= x3_ff;
      end
      if (t5) begin
         fx_ff <= sat_out(SW'(cfg.mount_x) + SW'(x4_ff));
         fy_ff <= sat_out(SW'(cfg.mount_y) + SW'(dy_ff));
         fz_ff <= sat_out(SW'(cfg.mount_z) + SW'(dz_ff));
      end
   end

   assign rsp_valid  = v5_ff;
   assign rsp_foot_x = fx_ff;
   assign rsp_foot_y = fy_ff;
   assign rsp_foot_z = fz_ff;

endmodule

// File: rtl/leg_forward_kinematics_unit.sv
// ----------------------------------------------------------------------------
// leg_forward_kinematics_unit
// Foot position of a three-joint leg from hip, thigh and calf angles.
// ----------------------------------------------------------------------------
// Requests carry three Q2.13 joint angles on req_*; results carry the foot
// position (Q1.16 metres, saturated to 18 bits) on rsp_*. A side is accepted
// on a clock edge with valid high and stall low.
// A request passes from a register that wraps and folds the angles,
// through one CORDIC cell per iteration, to the registered stages of link
// products, hip rotation and saturation, which give the result.
// Throughput is one request per cycle; every stage is a register with its
// own valid, so bubbles close up and a request is still taken while a
// result waits on rsp_stall, until the whole chain is full.
// The csr_* port writes the leg geometry; csr_ready is always high and
// unknown indexes are dropped. Write it only while no request is in flight.
// Reset empties the chain and loads the front-left leg geometry.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_hip_angle,
   input  logic signed [15:0]            req_thigh_angle,
   input  logic signed [15:0]            req_calf_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_x,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_y,
   output logic signed [lfk_pkg::OW-1:0] rsp_foot_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [17:0]                   csr_data
);
   import lfk_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic               stage_valid [0:CORDIC_STEPS];
   trio_type           stage_data  [0:CORDIC_STEPS];
   logic               stage_take  [0:CORDIC_STEPS+1];
   logic               prep_valid_ff;
   trio_type           prep_ff, prep_in;
   logic signed [16:0] pitch_sum;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_MOUNT_X:        cfg_in.mount_x        = $signed(csr_data);
            REG_MOUNT_Y:        cfg_in.mount_y        = $signed(csr_data);
            REG_MOUNT_Z:        cfg_in.mount_z        = $signed(csr_data);
            REG_RIGHT_SIDE:     cfg_in.right_side     = csr_data[0];
            REG_UPPER_LENGTH:   cfg_in.upper_length   = csr_data[15:0];
            REG_LOWER_LENGTH:   cfg_in.lower_length   = csr_data[15:0];
            REG_LATERAL_OFFSET: cfg_in.lateral_offset = csr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mount_x        <= 18'sd12675;
         cfg_ff.mount_y        <= 18'sd3047;
         cfg_ff.mount_z        <= '0;
         cfg_ff.right_side     <= 1'b0;
         cfg_ff.upper_length   <= 16'd13959;
         cfg_ff.lower_length   <= 16'd13960;
         cfg_ff.lateral_offset <= 16'd6259;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Angles to Q.30, wrap and fold.
   always_comb begin
      pitch_sum     = 17'(req_thigh_angle) + 17'(req_calf_angle);
      prep_in.hip   = prep_lane(AW'($signed({req_hip_angle, 17'b0})));
      prep_in.thigh = prep_lane(AW'($signed({req_thigh_angle, 17'b0})));
      prep_in.sum   = prep_lane(AW'($signed({pitch_sum, 17'b0})));
   end

   assign stage_take[0] = !prep_valid_ff || stage_take[1];
   assign req_stall     = !stage_take[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (stage_take[0]) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take[0]) begin
         prep_ff <= prep_in;
      end
   end

   assign stage_valid[0] = prep_valid_ff;
   assign stage_data[0]  = prep_ff;

   for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_cell
      lfk_cordic_cell #(
         .STEP (k - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (stage_valid[k-1]),
         .up_data   (stage_data[k-1]),
         .down_take (stage_take[k+1]),
         .valid     (stage_valid[k]),
         .data      (stage_data[k]),
         .take      (stage_take[k])
      );
   end

   lfk_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (stage_valid[CORDIC_STEPS]),
      .up_data    (stage_data[CORDIC_STEPS]),
      .cfg        (cfg_ff),
      .take       (stage_take[CORDIC_STEPS+1]),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_foot_x (rsp_foot_x),
      .rsp_foot_y (rsp_foot_y),
      .rsp_foot_z (rsp_foot_z)
   );

endmodule

// File: rtl/lfk_checker.sv
// ----------------------------------------------------------------------------
// lfk_checker
// Port-level checks of the leg forward kinematics unit.
// ----------------------------------------------------------------------------
`include "leg_forward_kinematics_unit_assert.svh"

module lfk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [17:0] rsp_foot_x,
   input logic [17:0] rsp_foot_y,
   input logic [17:0] rsp_foot_z
);

   // A stalled result holds.
   `LFK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_foot_x) && $stable(rsp_foot_y) && $stable(rsp_foot_z), "stalled result changed")

   // Backpressure on requests only comes from a stalled result.
   `LFK_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled result")

   // Reset leaves the chain empty and open.
   `LFK_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !req_stall, "chain not empty after reset")

endmodule

bind leg_forward_kinematics_unit lfk_checker u_checker (.*);
